>>> hw/rtl/dhcp_rop_pkg.sv
// Shared types, constants and helpers for the DHCP reply option parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dhcp_rop_pkg;

    // Message limits
    localparam int MAX_MESSAGE   = 552;
    localparam int OPTIONS_BYTES = 312;
    localparam int OPT_START     = 240;
    localparam int OPT_LIMIT     = (OPT_START + OPTIONS_BYTES < MAX_MESSAGE) ?
                                   (OPT_START + OPTIONS_BYTES) : MAX_MESSAGE;
    localparam int OFF_W         = $clog2(MAX_MESSAGE + 1);

    typedef logic [OFF_W-1:0] offset_t;

    // Fixed header offsets
    localparam int OFF_OP        = 0;
    localparam int OFF_XID_FIRST = 4;
    localparam int OFF_XID_LAST  = 7;
    localparam int OFF_YI_FIRST  = 16;
    localparam int OFF_YI_LAST   = 19;
    localparam int OFF_SI_FIRST  = 20;
    localparam int OFF_SI_LAST   = 23;

    // Byte codes
    localparam logic [7:0] OP_BOOTREPLY   = 8'd2;
    localparam logic [7:0] OPT_PAD        = 8'd0;
    localparam logic [7:0] OPT_END        = 8'd255;
    localparam logic [7:0] OPT_SUBNET     = 8'd1;
    localparam logic [7:0] OPT_ROUTER     = 8'd3;
    localparam logic [7:0] OPT_DNS        = 8'd6;
    localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID  = 8'd54;
    localparam logic [7:0] MSG_NAK        = 8'd6;
    localparam logic [7:0] WANTED_RESET   = 8'd2;
    localparam logic [31:0] DEFAULT_MASK  = 32'hFFFF_FF00;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRANSACTION_ID = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WANTED_TYPE    = 1'd1;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 168;

    typedef enum logic [1:0] {
        VERDICT_IGNORE = 2'd0,
        VERDICT_MATCH  = 2'd1,
        VERDICT_NAK    = 2'd2
    } verdict_t;

    // Tracked option slots; the enum value is the bit in the seen/valid masks
    typedef enum logic [2:0] {
        SLOT_TYPE   = 3'd0,
        SLOT_SERVER = 3'd1,
        SLOT_MASK   = 3'd2,
        SLOT_ROUTER = 3'd3,
        SLOT_DNS    = 3'd4,
        SLOT_NONE   = 3'd5
    } slot_t;

    localparam int NUM_SLOTS = 5;
    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] your_address;
        logic [31:0] server_address;
        logic [31:0] subnet_mask;
        logic [31:0] router_address;
        logic        has_router;
        logic [31:0] dns_server;
        logic        has_dns;
    } result_t;

    function automatic slot_t slot_of(input logic [7:0] code);
        slot_t s;
        unique case (code)
            OPT_MSG_TYPE:  s = SLOT_TYPE;
            OPT_SERVER_ID: s = SLOT_SERVER;
            OPT_SUBNET:    s = SLOT_MASK;
            OPT_ROUTER:    s = SLOT_ROUTER;
            OPT_DNS:       s = SLOT_DNS;
            default:       s = SLOT_NONE;
        endcase
        return s;
    endfunction

    // One-hot mask of a slot, zero for an untracked code
    function automatic slot_mask_t slot_bit(input slot_t s);
        slot_mask_t m;
        unique case (s)
            SLOT_TYPE:   m = 5'b00001;
            SLOT_SERVER: m = 5'b00010;
            SLOT_MASK:   m = 5'b00100;
            SLOT_ROUTER: m = 5'b01000;
            SLOT_DNS:    m = 5'b10000;
            default:     m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/dhcp_rop_parse.sv
// Per-byte message state: header checks, address capture, option TLV walk
// and the verdict on the last byte. Depends on dhcp_rop_pkg.
`timescale 1ns / 1ps

module dhcp_rop_parse
    import dhcp_rop_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  byte_valid,
    input  logic [7:0]            rx_byte,
    input  logic                  last_byte,
    output result_t               res,
    output logic                  res_valid
);

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_DONE
    } phase_t;

    logic [31:0] xid_reg;
    logic [7:0]  wanted_reg;

    offset_t     off_reg,    off_next;
    phase_t      phase_reg,  phase_next;
    logic [7:0]  code_reg,   code_next;
    logic [7:0]  left_reg,   left_next;
    logic [2:0]  idx_reg,    idx_next;     // saturates at 4
    logic        hdr_ok_reg, hdr_ok_next;
    logic        capt_reg,   capt_next;
    logic [31:0] yi_reg,     yi_next;
    logic [31:0] si_reg,     si_next;
    logic [7:0]  type_reg,   type_next;
    slot_mask_t  seen_reg,   seen_next;
    slot_mask_t  vflag_reg,  vflag_next;
    logic [31:0] server_reg, server_next;
    logic [31:0] mask_reg,   mask_next;
    logic [31:0] router_reg, router_next;
    logic [31:0] dns_reg,    dns_next;

    logic [7:0]  xid_byte;
    slot_t       slot;
    slot_mask_t  sbit;
    logic        in_msg;
    logic        in_opts;

    assign slot    = slot_of(code_reg);
    assign sbit    = slot_bit(slot);
    assign in_msg  = off_reg < offset_t'(MAX_MESSAGE);
    assign in_opts = (off_reg >= offset_t'(OPT_START)) && (off_reg < offset_t'(OPT_LIMIT));

    always_comb
    begin
        unique case (off_reg[1:0])
            2'd0:    xid_byte = xid_reg[31:24];
            2'd1:    xid_byte = xid_reg[23:16];
            2'd2:    xid_byte = xid_reg[15:8];
            default: xid_byte = xid_reg[7:0];
        endcase
    end

    always_comb
    begin
        off_next    = off_reg;
        phase_next  = phase_reg;
        code_next   = code_reg;
        left_next   = left_reg;
        idx_next    = idx_reg;
        hdr_ok_next = hdr_ok_reg;
        capt_next   = capt_reg;
        yi_next     = yi_reg;
        si_next     = si_reg;
        type_next   = type_reg;
        seen_next   = seen_reg;
        vflag_next  = vflag_reg;
        server_next = server_reg;
        mask_next   = mask_reg;
        router_next = router_reg;
        dns_next    = dns_reg;

        if (in_msg)
        begin
            if (off_reg == offset_t'(OFF_OP) && rx_byte != OP_BOOTREPLY)
                hdr_ok_next = 1'b0;
            if (off_reg >= offset_t'(OFF_XID_FIRST) && off_reg <= offset_t'(OFF_XID_LAST)
                && rx_byte != xid_byte)
                hdr_ok_next = 1'b0;
            if (off_reg >= offset_t'(OFF_YI_FIRST) && off_reg <= offset_t'(OFF_YI_LAST))
                yi_next = {yi_reg[23:0], rx_byte};
            if (off_reg >= offset_t'(OFF_SI_FIRST) && off_reg <= offset_t'(OFF_SI_LAST))
                si_next = {si_reg[23:0], rx_byte};

            if (in_opts)
            begin
                unique case (phase_reg)
                    PH_CODE:
                    begin
                        if (rx_byte == OPT_END)
                            phase_next = PH_DONE;
                        else if (rx_byte != OPT_PAD)
                        begin
                            code_next  = rx_byte;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        left_next = rx_byte;
                        idx_next  = 3'd0;
                        capt_next = 1'b0;
                        // only the first occurrence of a tracked code counts
                        if ((seen_reg & sbit) == '0 && slot != SLOT_NONE)
                        begin
                            seen_next = seen_reg | sbit;
                            unique case (slot)
                                SLOT_TYPE:                capt_next = rx_byte == 8'd1;
                                SLOT_SERVER, SLOT_MASK:   capt_next = rx_byte == 8'd4;
                                default:                  capt_next = rx_byte >= 8'd4;
                            endcase
                        end
                        phase_next = (rx_byte != 8'd0) ? PH_VALUE : PH_CODE;
                    end
                    PH_VALUE:
                    begin
                        if (capt_reg && !idx_reg[2])
                        begin
                            unique case (slot)
                                SLOT_TYPE:
                                begin
                                    if (idx_reg == 3'd0)
                                    begin
                                        type_next  = rx_byte;
                                        vflag_next = vflag_reg | sbit;
                                    end
                                end
                                SLOT_SERVER: server_next = {server_reg[23:0], rx_byte};
                                SLOT_MASK:   mask_next   = {mask_reg[23:0], rx_byte};
                                SLOT_ROUTER: router_next = {router_reg[23:0], rx_byte};
                                SLOT_DNS:    dns_next    = {dns_reg[23:0], rx_byte};
                                default:     ;
                            endcase
                            if (idx_reg == 3'd3 && slot != SLOT_TYPE)
                                vflag_next = vflag_reg | sbit;
                        end
                        if (!idx_reg[2])
                            idx_next = idx_reg + 3'd1;
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                            phase_next = PH_CODE;
                    end
                    PH_DONE: ;
                endcase
            end
            off_next = off_reg + offset_t'(1);
        end
    end

    // Result from the updated state of the last byte
    always_comb
    begin
        res.verdict = VERDICT_IGNORE;
        if (off_next >= offset_t'(OPT_START) && hdr_ok_next && vflag_next[SLOT_TYPE])
        begin
            if (type_next == wanted_reg)
                res.verdict = VERDICT_MATCH;
            else if (type_next == MSG_NAK)
                res.verdict = VERDICT_NAK;
        end
        res.your_address   = yi_next;
        res.server_address = vflag_next[SLOT_SERVER] ? server_next : si_next;
        res.subnet_mask    = vflag_next[SLOT_MASK] ? mask_next : DEFAULT_MASK;
        res.router_address = vflag_next[SLOT_ROUTER] ? router_next : 32'd0;
        res.has_router     = vflag_next[SLOT_ROUTER];
        res.dns_server     = vflag_next[SLOT_DNS] ? dns_next : 32'd0;
        res.has_dns        = vflag_next[SLOT_DNS];
    end

    assign res_valid = byte_valid && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xid_reg    <= '0;
            wanted_reg <= WANTED_RESET;
            off_reg    <= '0;
            phase_reg  <= PH_CODE;
            code_reg   <= '0;
            left_reg   <= '0;
            idx_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            capt_reg   <= 1'b0;
            yi_reg     <= '0;
            si_reg     <= '0;
            type_reg   <= '0;
            seen_reg   <= '0;
            vflag_reg  <= '0;
            server_reg <= '0;
            mask_reg   <= '0;
            router_reg <= '0;
            dns_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_TRANSACTION_ID: xid_reg    <= cfg_wdata;
                    CFG_WANTED_TYPE:    wanted_reg <= cfg_wdata[7:0];
                    default:            ;
                endcase
            end

            if (byte_valid && last_byte)
            begin
                // message done: back to the clean state for the next one
                off_reg    <= '0;
                phase_reg  <= PH_CODE;
                code_reg   <= '0;
                left_reg   <= '0;
                idx_reg    <= '0;
                hdr_ok_reg <= 1'b1;
                capt_reg   <= 1'b0;
                yi_reg     <= '0;
                si_reg     <= '0;
                type_reg   <= '0;
                seen_reg   <= '0;
                vflag_reg  <= '0;
                server_reg <= '0;
                mask_reg   <= '0;
                router_reg <= '0;
                dns_reg    <= '0;
            end
            else if (byte_valid)
            begin
                off_reg    <= off_next;
                phase_reg  <= phase_next;
                code_reg   <= code_next;
                left_reg   <= left_next;
                idx_reg    <= idx_next;
                hdr_ok_reg <= hdr_ok_next;
                capt_reg   <= capt_next;
                yi_reg     <= yi_next;
                si_reg     <= si_next;
                type_reg   <= type_next;
                seen_reg   <= seen_next;
                vflag_reg  <= vflag_next;
                server_reg <= server_next;
                mask_reg   <= mask_next;
                router_reg <= router_next;
                dns_reg    <= dns_next;
            end
        end
    end

endmodule

>>> hw/rtl/dhcp_rop_out.sv
// Output register stage: holds one result word until the sink takes it.
// Depends on dhcp_rop_pkg.
`timescale 1ns / 1ps

module dhcp_rop_out
    import dhcp_rop_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  result_t res,
    input  logic    res_valid,
    output logic    free,
    output result_t out_data,
    output logic    out_valid,
    input  logic    out_ready
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // a result only arrives in a cycle where free was high
    assign free       = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            data_reg <= res;
    end

    assign out_data  = data_reg;
    assign out_valid = valid_reg;

endmodule

>>> hw/rtl/dhcp_reply_option_parser.sv
// Top level of the DHCP reply option parser: byte stream in, one lease
// result word per message out. Depends on dhcp_rop_pkg, dhcp_rop_parse, dhcp_rop_out.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] rx_byte, s_tlast last_byte
// m_*       out  m_tvalid/m_tready  m_tdata: verdict, addresses, mask, router, dns
// cfg_*     in   cfg_we             cfg_addr index, cfg_wdata value
//
// One byte is taken per cycle while s_tready is high; each byte updates the message state in a single
// pass of logic. The byte marked tlast loads the result register, so the result
// word shows on m_* in the cycle after that byte is accepted.
// s_tready drops only while a result waits in the output register and m_tready is low.
// Reset gives transaction id 0, wanted type 2 and a clean message state.

module dhcp_reply_option_parser
    import dhcp_rop_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] verdict, [33:2] your_address, [65:34] server_address,
    // [97:66] subnet_mask, [129:98] router_address, [130] has_router,
    // [162:131] dns_server, [163] has_dns, [167:164] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata
);

    logic    accept;
    logic    free;
    result_t res;
    logic    res_valid;
    result_t out_data;

    assign s_tready = free;
    assign accept   = s_tvalid && free;

    dhcp_rop_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (accept),
        .rx_byte    (s_tdata[7:0]),
        .last_byte  (s_tlast),
        .res        (res),
        .res_valid  (res_valid)
    );

    dhcp_rop_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .free      (free),
        .out_data  (out_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

    // pack fields highest first, so verdict sits in the lowest bits
    assign m_tdata = {4'd0,
                      out_data.has_dns,
                      out_data.dns_server,
                      out_data.has_router,
                      out_data.router_address,
                      out_data.subnet_mask,
                      out_data.server_address,
                      out_data.your_address,
                      out_data.verdict};

endmodule

>>> hw/rtl/dhcp_rop_check.sv
// Port-level checks for the DHCP reply option parser, bound to the top level.
// Depends on dhcp_rop_pkg and dhcp_reply_option_parser.
`timescale 1ns / 1ps

module dhcp_rop_check
    import dhcp_rop_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a result follows each accepted last byte
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last byte");

    // a new result only after a last byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without last byte");

    // input never blocked while the output register is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // router address is zero without a usable router option
    a_router: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[130] |-> m_tdata[129:98] == 32'd0)
        else $error("router address without router flag");

endmodule

bind dhcp_reply_option_parser dhcp_rop_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
